[hw/rtl/mfhe_pkg.sv]
// Shared types and constants of the masked frame header encoder.
// Used by the front end, the command queue, the byte sequencer and the top level.
// No dependencies.
package mfhe_pkg;

  localparam logic       MODE_START   = 1'b0;
  localparam logic       MODE_PAYLOAD = 1'b1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_LINK_CLOSED = 2'd1;
  localparam logic [1:0] ST_NO_FRAME    = 2'd2;
  localparam logic [1:0] ST_FRAME_BUSY  = 2'd3;

  localparam logic [15:0] SHORT_LEN_MAX = 16'd125;
  localparam logic [6:0]  LEN16_CODE    = 7'd126;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // One queued command: either a finished single result or a whole header.
  typedef struct packed {
    logic        hdr;
    logic [7:0]  byte0;
    logic        done;
    logic [1:0]  status;
    logic [15:0] len;
    logic [31:0] key;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

[hw/rtl/masked_frame_header_encoder.sv]
// Client-side masked frame encoder. A payload transaction or a rejected
// transaction yields one output byte, and the input side accepts one transaction
// per cycle while the queue is not full; a frame start yields a six-byte header
// (length up to 125) or an eight-byte header (16-bit extended length), which the
// byte sequencer emits one byte per cycle while out_tready is high, so sustained
// output is one byte per cycle with the sequencer as the limit. A four-entry
// command queue lets the front end keep accepting while a header is being sent.
// Data passes the queue, then the output register. No clearing pass is needed
// after reset. Depends on mfhe_pkg, mfhe_front, mfhe_queue and mfhe_back.
module masked_frame_header_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // link_open
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode_in[3:0], rsv_bits[6:4], frame_length[22:7], mask_key[54:23],
  // payload_byte[62:55], zero [63]
  input  logic [63:0] in_tdata,
  input  logic [0:0]  in_tuser,      // mode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,     // out_byte[7:0]
  output logic        out_tlast,     // frame_done
  output logic [1:0]  out_tuser      // status[1:0]
);

  mfhe_pkg::q_status_t q_stat;
  mfhe_pkg::cmd_t      q_wdata;
  mfhe_pkg::cmd_t      q_rdata;
  logic                q_push;
  logic                q_pop;

  mfhe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  mfhe_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  mfhe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rdata    (q_rdata),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

[hw/rtl/mfhe_front.sv]
// Front end: accepts input transactions, checks them against the frame state
// and turns each into one queue command. Depends on mfhe_pkg.
module mfhe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,
  input  logic [0:0]           in_tuser,
  input  mfhe_pkg::q_status_t  q_stat,
  output logic                 q_push,
  output mfhe_pkg::cmd_t       q_wdata
);

  logic        link_open_r;
  logic [31:0] key_store_r,    key_store_nxt;
  logic [15:0] bytes_left_r,   bytes_left_nxt;
  logic [1:0]  key_phase_r,    key_phase_nxt;
  logic        frame_active_r, frame_active_nxt;

  logic [3:0]  opc;
  logic [2:0]  rsv;
  logic [15:0] len;
  logic [31:0] key;
  logic [7:0]  pb;
  logic [7:0]  kb;
  logic [15:0] left_dec;
  logic        accept;

  assign opc = in_tdata[3:0];
  assign rsv = in_tdata[6:4];
  assign len = in_tdata[22:7];
  assign key = in_tdata[54:23];
  assign pb  = in_tdata[62:55];

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;
  assign q_push    = accept;

  assign kb       = key_store_r[{key_phase_r, 3'b000} +: 8];
  assign left_dec = bytes_left_r - 16'd1;

  always_comb begin
    q_wdata          = '0;
    key_store_nxt    = key_store_r;
    bytes_left_nxt   = bytes_left_r;
    key_phase_nxt    = key_phase_r;
    frame_active_nxt = frame_active_r;
    if (in_tuser[0] == mfhe_pkg::MODE_START) begin
      if (!link_open_r) begin
        q_wdata.status = mfhe_pkg::ST_LINK_CLOSED;
      end else if (frame_active_r) begin
        q_wdata.status = mfhe_pkg::ST_FRAME_BUSY;
      end else begin
        q_wdata.hdr      = 1'b1;
        q_wdata.byte0    = {1'b1, rsv, opc};
        q_wdata.status   = mfhe_pkg::ST_OK;
        q_wdata.len      = len;
        q_wdata.key      = key;
        key_store_nxt    = key;
        bytes_left_nxt   = len;
        key_phase_nxt    = 2'd0;
        frame_active_nxt = (len != 16'd0);
      end
    end else begin
      if (!frame_active_r) begin
        q_wdata.status = mfhe_pkg::ST_NO_FRAME;
      end else begin
        q_wdata.byte0    = pb ^ kb;
        q_wdata.done     = (left_dec == 16'd0);
        q_wdata.status   = mfhe_pkg::ST_OK;
        bytes_left_nxt   = left_dec;
        key_phase_nxt    = key_phase_r + 2'd1;
        frame_active_nxt = (left_dec != 16'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_open_r    <= 1'b0;
      key_store_r    <= '0;
      bytes_left_r   <= '0;
      key_phase_r    <= '0;
      frame_active_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        link_open_r <= cfg_wr_data;
      end
      if (accept) begin
        key_store_r    <= key_store_nxt;
        bytes_left_r   <= bytes_left_nxt;
        key_phase_r    <= key_phase_nxt;
        frame_active_r <= frame_active_nxt;
      end
    end
  end

endmodule

[hw/rtl/mfhe_queue.sv]
// Short command queue between the front end and the byte sequencer.
// Depends on mfhe_pkg for the command type and depth.
module mfhe_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  mfhe_pkg::cmd_t       wdata,
  input  logic                 pop,
  output mfhe_pkg::cmd_t       rdata,
  output mfhe_pkg::q_status_t  stat
);

  localparam int unsigned CNT_W = $clog2(mfhe_pkg::QDEPTH + 1);

  mfhe_pkg::cmd_t                 mem_r [mfhe_pkg::QDEPTH];
  logic [mfhe_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [mfhe_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]               count_r;
  logic                           do_push;
  logic                           do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(mfhe_pkg::QDEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/mfhe_back.sv]
// Byte sequencer: takes commands from the queue and drives the output register,
// spreading a header over six or eight bytes. Depends on mfhe_pkg.
module mfhe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mfhe_pkg::cmd_t       q_rdata,
  input  mfhe_pkg::q_status_t  q_stat,
  output logic                 q_pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tlast,
  output logic [1:0]           out_tuser
);

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r,  out_byte_nxt;
  logic        out_last_r,  out_last_nxt;
  logic [1:0]  out_stat_r,  out_stat_nxt;
  logic        hdr_active_r, hdr_active_nxt;
  logic [2:0]  step_r,      step_nxt;
  logic [15:0] len_r,       len_nxt;
  logic [31:0] key_r,       key_nxt;

  logic        advance;
  logic        long_len;
  logic [2:0]  last_step;
  logic [1:0]  key_idx;
  logic [7:0]  hdr_byte;

  assign advance   = !out_valid_r || out_tready;
  assign q_pop     = advance && !hdr_active_r && !q_stat.empty;
  assign long_len  = (len_r > mfhe_pkg::SHORT_LEN_MAX);
  assign last_step = long_len ? 3'd7 : 3'd5;
  assign key_idx   = long_len ? 2'(step_r - 3'd4) : 2'(step_r - 3'd2);

  // Header bytes after the first: length byte, optional extended length, key.
  always_comb begin
    if (step_r == 3'd1) begin
      hdr_byte = long_len ? {1'b1, mfhe_pkg::LEN16_CODE} : {1'b1, len_r[6:0]};
    end else if (long_len && step_r == 3'd2) begin
      hdr_byte = len_r[15:8];
    end else if (long_len && step_r == 3'd3) begin
      hdr_byte = len_r[7:0];
    end else begin
      hdr_byte = key_r[{key_idx, 3'b000} +: 8];
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_stat_nxt   = out_stat_r;
    hdr_active_nxt = hdr_active_r;
    step_nxt       = step_r;
    len_nxt        = len_r;
    key_nxt        = key_r;
    if (advance) begin
      if (hdr_active_r) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = hdr_byte;
        out_stat_nxt  = mfhe_pkg::ST_OK;
        out_last_nxt  = (step_r == last_step) && (len_r == 16'd0);
        step_nxt      = step_r + 3'd1;
        if (step_r == last_step) begin
          hdr_active_nxt = 1'b0;
        end
      end else if (!q_stat.empty) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = q_rdata.byte0;
        out_last_nxt  = q_rdata.done;
        out_stat_nxt  = q_rdata.status;
        if (q_rdata.hdr) begin
          hdr_active_nxt = 1'b1;
          step_nxt       = 3'd1;
          len_nxt        = q_rdata.len;
          key_nxt        = q_rdata.key;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      hdr_active_r <= 1'b0;
      step_r       <= '0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      hdr_active_r <= hdr_active_nxt;
      step_r       <= step_nxt;
    end
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_stat_r <= out_stat_nxt;
    len_r      <= len_nxt;
    key_r      <= key_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_stat_r;

endmodule
